// ===== rtl/ssne_pkg.sv =====
// ssne_pkg: shared types, constants and the glyph table of the seven-segment
// number encoder. No dependencies; every other file of the block imports it.
package ssne_pkg;

    localparam int unsigned ValueW   = 16;
    localparam int unsigned SegW     = 8;
    localparam int unsigned DigitW   = 4;
    localparam int unsigned NumDigits = 4;
    localparam int unsigned BinW     = 14;   // enough for 9999
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 2;

    localparam logic [BinW-1:0] DecMax   = 14'd9999;
    localparam int unsigned     DecThou  = 1000;
    localparam int unsigned     DecHund  = 100;
    localparam int unsigned     DecTen   = 10;
    localparam logic [SegW-1:0] SegDp    = 8'h08;  // point bit, order F A E D DP C G B
    localparam logic [SegW-1:0] SegBlank = 8'h00;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DISPLAY_HEX    = 2'd0,
        CFG_POINT_POSITION = 2'd1,
        CFG_COMMON_CATHODE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic       display_hex;
        logic [1:0] point_position;
        logic       common_cathode;
    } t_cfg;

    typedef struct packed {
        logic [SegW-1:0] seg_digit0;
        logic [SegW-1:0] seg_digit1;
        logic [SegW-1:0] seg_digit2;
        logic [SegW-1:0] seg_digit3;
        logic            saturated;
    } t_result;

    // segment pattern of one digit, 0-9 then A b C d E F
    function automatic logic [SegW-1:0] f_glyph(input logic [DigitW-1:0] d);
        logic [SegW-1:0] g;
        unique case (d)
            4'h0: g = 8'hF5;
            4'h1: g = 8'h05;
            4'h2: g = 8'h73;
            4'h3: g = 8'h57;
            4'h4: g = 8'h87;
            4'h5: g = 8'hD6;
            4'h6: g = 8'hF6;
            4'h7: g = 8'hC5;
            4'h8: g = 8'hF7;
            4'h9: g = 8'hC7;
            4'hA: g = 8'hE7;
            4'hB: g = 8'hB6;
            4'hC: g = 8'hF0;
            4'hD: g = 8'h37;
            4'hE: g = 8'hF2;
            default: g = 8'hE2;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/ssne_in_if.sv =====
// ssne_in_if: valid/ready channel carrying the value to display.
// Depends on ssne_pkg for the field width.
interface ssne_in_if import ssne_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ValueW-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/ssne_out_if.sv =====
// ssne_out_if: valid/ready channel carrying four segment patterns and the
// saturation flag. Depends on ssne_pkg for the field widths.
interface ssne_out_if import ssne_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [SegW-1:0] seg_digit0;
    logic [SegW-1:0] seg_digit1;
    logic [SegW-1:0] seg_digit2;
    logic [SegW-1:0] seg_digit3;
    logic            saturated;

    modport source (output valid, output seg_digit0, output seg_digit1,
                    output seg_digit2, output seg_digit3, output saturated,
                    input ready);
    modport sink   (input valid, input seg_digit0, input seg_digit1,
                    input seg_digit2, input seg_digit3, input saturated,
                    output ready);
endinterface

// ===== rtl/ssne_encode.sv =====
// ssne_encode: combinational digit split, blanking and glyph lookup for one
// value. Depends on ssne_pkg.
module ssne_encode import ssne_pkg::*; (
    input  logic [ValueW-1:0] i_value,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    logic [BinW-1:0]   clamped;
    logic              sat;
    logic [DigitW-1:0] dec [NumDigits];
    logic [DigitW-1:0] dig [NumDigits];
    logic [9:0]        rem_h;
    logic [6:0]        rem_t;
    logic [3:0]        rem_u;
    logic [2:0]        point_digit;   // four means none
    logic [2:0]        blank_limit;
    logic              leading;
    logic [SegW-1:0]   seg [NumDigits];

    // clamp to four decimal digits
    always_comb begin
        sat     = (i_value > ValueW'(DecMax));
        clamped = sat ? DecMax : i_value[BinW-1:0];
    end

    // decimal split by compare-and-subtract against constant multiples
    always_comb begin
        dec[0] = '0;
        rem_h  = clamped[9:0];
        for (int k = 1; k <= 9; k++) begin
            if (clamped >= BinW'(k * DecThou)) begin
                dec[0] = DigitW'(k);
                rem_h  = 10'(clamped - BinW'(k * DecThou));
            end
        end
        dec[1] = '0;
        rem_t  = rem_h[6:0];
        for (int k = 1; k <= 9; k++) begin
            if (rem_h >= 10'(k * DecHund)) begin
                dec[1] = DigitW'(k);
                rem_t  = 7'(rem_h - 10'(k * DecHund));
            end
        end
        dec[2] = '0;
        rem_u  = rem_t[3:0];
        for (int k = 1; k <= 9; k++) begin
            if (rem_t >= 7'(k * DecTen)) begin
                dec[2] = DigitW'(k);
                rem_u  = 4'(rem_t - 7'(k * DecTen));
            end
        end
        dec[3] = rem_u;
    end

    always_comb begin
        if (i_cfg.display_hex) begin
            dig[0]      = i_value[15:12];
            dig[1]      = i_value[11:8];
            dig[2]      = i_value[7:4];
            dig[3]      = i_value[3:0];
            point_digit = 3'd4;
            blank_limit = 3'd3;
        end else begin
            dig = dec;
            if (i_cfg.point_position != 2'd0) begin
                point_digit = 3'd3 - {1'b0, i_cfg.point_position};
                blank_limit = point_digit;
            end else begin
                point_digit = 3'd4;
                blank_limit = 3'd3;
            end
        end
    end

    // blank leading zeros left of the limit, then light the point
    always_comb begin
        leading = 1'b1;
        for (int i = 0; i < NumDigits; i++) begin
            if (dig[i] != '0) begin
                leading = 1'b0;
            end
            if (leading && (3'(i) < blank_limit)) begin
                seg[i] = SegBlank;
            end else begin
                seg[i] = f_glyph(dig[i]) | ((3'(i) == point_digit) ? SegDp : SegBlank);
            end
            if (!i_cfg.common_cathode) begin
                seg[i] = ~seg[i];
            end
        end
    end

    assign o_result.seg_digit0 = seg[0];
    assign o_result.seg_digit1 = seg[1];
    assign o_result.seg_digit2 = seg[2];
    assign o_result.seg_digit3 = seg[3];
    assign o_result.saturated  = sat & ~i_cfg.display_hex;

endmodule

// ===== rtl/seven_segment_number_encoder.sv =====
// seven_segment_number_encoder: top level, input register, configuration
// registers and result register around ssne_encode.
// Depends on ssne_pkg, ssne_in_if, ssne_out_if and ssne_encode.
//
//  channel   direction  payload                               handshake
//  i_in      sink       value[15:0]                           valid/ready
//  o_out     source     seg_digit0..3[7:0], saturated         valid/ready
//  cfg       write      i_cfg_index[1:0], i_cfg_data[1:0]     i_cfg_we
//
// one value per clock sustained while o_out is ready; a result passes through
// the input register, then the result register
// the only path between the registers is the decimal split, blanking and
// glyph lookup in ssne_encode
// i_rst_n is synchronous, active low; it clears the valid flags and the
// configuration registers (hex off, no point, common anode)
// a stall on o_out fills the input register and only then drops i_in.ready
module seven_segment_number_encoder import ssne_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ssne_in_if.sink             i_in,
    ssne_out_if.source          o_out,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    // input register stage
    logic              r_in_valid;
    logic [ValueW-1:0] r_in_value;

    // result register stage
    logic              r_out_valid;
    t_result           r_out;

    t_result           n_out;
    logic              out_take;   // result register free for a new item
    logic              in_take;    // input register free for a new item

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISPLAY_HEX:    r_cfg.display_hex    <= i_cfg_data[0];
                CFG_POINT_POSITION: r_cfg.point_position <= i_cfg_data[1:0];
                CFG_COMMON_CATHODE: r_cfg.common_cathode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_take   = !r_out_valid || o_out.ready;
    assign in_take    = !r_in_valid || out_take;
    assign i_in.ready = in_take;

    // input stage: capture on transfer, empty when passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in.valid) begin
            r_in_value <= i_in.value;
        end
    end

    // the whole conversion sits between the two stages
    ssne_encode u_encode (
        .i_value  (r_in_value),
        .i_cfg    (r_cfg),
        .o_result (n_out)
    );

    // result stage: holds while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.seg_digit0 = r_out.seg_digit0;
    assign o_out.seg_digit1 = r_out.seg_digit1;
    assign o_out.seg_digit2 = r_out.seg_digit2;
    assign o_out.seg_digit3 = r_out.seg_digit3;
    assign o_out.saturated  = r_out.saturated;

endmodule

// ===== rtl/ssne_checker.sv =====
// ssne_checker: port-level assertions on the seven-segment number encoder,
// attached by bind. Depends on ssne_pkg and the top level's ports.
module ssne_checker import ssne_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [SegW-1:0] i_seg_digit3,
    input logic            i_saturated
);

    // a stalled result stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result holds its rightmost pattern
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_seg_digit3))
        else $error("result changed while stalled");

    // with nothing waiting at the output the block takes input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // a clamped value shows nine on the rightmost digit, either polarity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> (i_seg_digit3 == 8'hC7 || i_seg_digit3 == 8'h38))
        else $error("saturated result does not end in nine");

endmodule

bind seven_segment_number_encoder ssne_checker u_ssne_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_seg_digit3 (o_out.seg_digit3),
    .i_saturated  (o_out.saturated)
);
